// ===== rtl/xsa_pkg.sv =====
// shared types and constants for the crossbar switch arbiter
package xsa_pkg;

  localparam int NODES       = 8;
  localparam int NODE_W      = 3;
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = 3;
  localparam int CNT_W       = 4;
  localparam int DATA_WIDTH  = 32;
  localparam int STEP_W      = NODE_W + 1;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_ADV  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MODE      = 2'd0,
    REG_IN_LIMIT  = 2'd1,
    REG_OUT_LIMIT = 2'd2,
    REG_GRANT     = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_POP,
    S_POPW,
    S_SCAN,
    S_ARB,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              mode;
    logic [3:0]        in_limit;
    logic [3:0]        out_limit;
    logic [7:0]        grant_period;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic              push;
    logic              pop;
    logic              pop_cap;
    logic              rd_en;
    logic              cap_en;
    logic              arb;
    logic              finish;
    logic [NODE_W-1:0] rd_idx;
    logic [NODE_W-1:0] cap_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic pop_hit;
  } dp_sts_t;

  // limits above the queue depth saturate
  function automatic logic [CNT_W-1:0] eff_limit(input logic [3:0] lim);
    return (lim > 4'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH) : lim;
  endfunction

endpackage

// ===== rtl/xsa_ctrl.sv =====
// controller state machine sequencing push, pop and advance transactions
module xsa_ctrl import xsa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  input  dp_sts_t sts,
  output dp_cmd_t dcmd,
  output logic    busy,
  output logic    done
);

  state_t              state, state_next;
  logic [STEP_W-1:0]   cnt, cnt_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    dcmd       = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          dcmd.load = 1'b1;
          cnt_next  = '0;
          case (cmd)
            CMD_PUSH: state_next = S_PUSH;
            CMD_POP:  state_next = S_POP;
            CMD_ADV:  state_next = S_SCAN;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_PUSH: begin
        dcmd.push  = 1'b1;
        state_next = S_DONE;
      end
      S_POP: begin
        dcmd.pop   = 1'b1;
        state_next = sts.pop_hit ? S_POPW : S_DONE;
      end
      S_POPW: begin
        dcmd.pop_cap = 1'b1;
        state_next   = S_DONE;
      end
      S_SCAN: begin
        // read one head entry per cycle, capture it the cycle after
        dcmd.rd_en   = (cnt != STEP_W'(NODES));
        dcmd.cap_en  = (cnt != '0);
        dcmd.rd_idx  = cnt[NODE_W-1:0];
        dcmd.cap_idx = NODE_W'(cnt - 1'b1);
        if (cnt == STEP_W'(NODES)) begin
          state_next = S_ARB;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ARB: begin
        dcmd.arb    = 1'b1;
        dcmd.rd_idx = cnt[NODE_W-1:0];
        if (cnt == STEP_W'(NODES - 1)) begin
          dcmd.finish = 1'b1;
          state_next  = S_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  // a result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held");

  // an accepted transaction makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transaction accepted without going busy");

endmodule

// ===== rtl/xsa_dp.sv =====
// datapath: queue memories, queue counters, arbitration and results
module xsa_dp import xsa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  dp_cmd_t               dcmd,
  output dp_sts_t               sts,
  input  logic [NODE_W-1:0]     src_node,
  input  logic [NODE_W-1:0]     dst_node,
  input  logic [DATA_WIDTH-1:0] payload,
  input  logic [NODE_W-1:0]     pop_node,
  output logic                  push_accepted,
  output logic                  pop_valid,
  output logic [DATA_WIDTH-1:0] pop_data,
  output logic [3:0]            grants,
  output logic [3:0]            conflicts,
  output logic                  busy_res
);

  localparam int IN_W = NODE_W + DATA_WIDTH;

  // queue stores
  logic [IN_W-1:0]       in_mem  [NODES*QUEUE_DEPTH];
  logic [DATA_WIDTH-1:0] out_mem [NODES*QUEUE_DEPTH];
  logic [IN_W-1:0]       in_rd;
  logic [DATA_WIDTH-1:0] out_rd;

  // latched transaction
  logic [NODE_W-1:0]     src_q, dst_q, pn_q;
  logic [DATA_WIDTH-1:0] pay_q;

  // queue control
  logic [QPTR_W-1:0] in_head  [NODES];
  logic [CNT_W-1:0]  in_cnt   [NODES];
  logic [QPTR_W-1:0] out_head [NODES];
  logic [CNT_W-1:0]  out_cnt  [NODES];

  // arbiter state
  logic [NODE_W-1:0] rot;
  logic [NODE_W-1:0] ptr [NODES];
  logic [7:0]        cdown;

  // per-tick head snapshot
  logic [NODE_W-1:0]     hd_dest [NODES];
  logic [DATA_WIDTH-1:0] hd_pay  [NODES];
  logic [NODES-1:0]      nz, seen, issued;

  logic [CNT_W-1:0] lim_in, lim_out;
  logic             push_ok, pop_hit;
  logic [NODE_W-1:0] cap_dest;
  logic             cap_nz;

  // arbitration step
  logic [NODE_W-1:0] rr_n, rr_d, sl_d, sl_n, mv_n, mv_d;
  logic              rr_move, rr_conf, sl_found, sl_move, mv;
  logic [QPTR_W-1:0] mv_tail;

  assign lim_in  = eff_limit(cfg.in_limit);
  assign lim_out = eff_limit(cfg.out_limit);
  assign push_ok = in_cnt[src_q] < lim_in;
  assign pop_hit = out_cnt[pn_q] != '0;
  assign sts.pop_hit = pop_hit;

  assign cap_dest = in_rd[IN_W-1:DATA_WIDTH];
  assign cap_nz   = in_cnt[dcmd.cap_idx] != '0;

  // round robin: one input per step from the rotating start
  always_comb begin
    rr_n    = dcmd.rd_idx + rot;
    rr_d    = hd_dest[rr_n];
    rr_move = nz[rr_n] && !issued[rr_d] && (out_cnt[rr_d] < lim_out);
    rr_conf = nz[rr_n] && issued[rr_d];
  end

  // islip: one output per step, first requester above its pointer
  always_comb begin
    sl_d     = dcmd.rd_idx;
    sl_n     = '0;
    sl_found = 1'b0;
    for (int k = 1; k <= NODES; k++) begin
      if (!sl_found && nz[NODE_W'(ptr[sl_d] + k)] &&
          (hd_dest[NODE_W'(ptr[sl_d] + k)] == sl_d)) begin
        sl_found = 1'b1;
        sl_n     = NODE_W'(ptr[sl_d] + k);
      end
    end
    sl_move = seen[sl_d] && (out_cnt[sl_d] < lim_out) && sl_found;
  end

  assign mv      = dcmd.arb && (cfg.mode ? sl_move : rr_move);
  assign mv_n    = cfg.mode ? sl_n : rr_n;
  assign mv_d    = cfg.mode ? sl_d : rr_d;
  assign mv_tail = out_head[mv_d] + out_cnt[mv_d][QPTR_W-1:0];

  // input queue memory
  always_ff @(posedge clk) begin
    if (dcmd.push && push_ok) begin
      in_mem[{src_q, in_head[src_q] + in_cnt[src_q][QPTR_W-1:0]}] <= {dst_q, pay_q};
    end
    if (dcmd.rd_en) begin
      in_rd <= in_mem[{dcmd.rd_idx, in_head[dcmd.rd_idx]}];
    end
  end

  // output queue memory
  always_ff @(posedge clk) begin
    if (mv) begin
      out_mem[{mv_d, mv_tail}] <= hd_pay[mv_n];
    end
    if (dcmd.pop && pop_hit) begin
      out_rd <= out_mem[{pn_q, out_head[pn_q]}];
    end
  end

  // transaction latch and head snapshot
  always_ff @(posedge clk) begin
    if (dcmd.load) begin
      src_q <= src_node;
      dst_q <= dst_node;
      pay_q <= payload;
      pn_q  <= pop_node;
    end
    if (dcmd.cap_en) begin
      hd_dest[dcmd.cap_idx] <= cap_dest;
      hd_pay[dcmd.cap_idx]  <= in_rd[DATA_WIDTH-1:0];
    end
  end

  // queue control, arbiter state and results
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODES; i++) begin
        in_head[i]  <= '0;
        in_cnt[i]   <= '0;
        out_head[i] <= '0;
        out_cnt[i]  <= '0;
        ptr[i]      <= '0;
      end
      rot           <= '0;
      cdown         <= 8'd1;
      nz            <= '0;
      seen          <= '0;
      issued        <= '0;
      push_accepted <= 1'b0;
      pop_valid     <= 1'b0;
      pop_data      <= '0;
      grants        <= '0;
      conflicts     <= '0;
    end else begin
      if (dcmd.load) begin
        nz            <= '0;
        seen          <= '0;
        issued        <= '0;
        push_accepted <= 1'b0;
        pop_valid     <= 1'b0;
        pop_data      <= '0;
        grants        <= '0;
        conflicts     <= '0;
      end
      // push
      if (dcmd.push && push_ok) begin
        in_cnt[src_q] <= in_cnt[src_q] + 1'b1;
        push_accepted <= 1'b1;
      end
      // pop
      if (dcmd.pop && pop_hit) begin
        out_head[pn_q] <= out_head[pn_q] + 1'b1;
        out_cnt[pn_q]  <= out_cnt[pn_q] - 1'b1;
        pop_valid      <= 1'b1;
      end
      if (dcmd.pop_cap) begin
        pop_data <= out_rd;
      end
      // snapshot: requests and islip conflicts on a shared destination
      if (dcmd.cap_en) begin
        nz[dcmd.cap_idx] <= cap_nz;
        if (cap_nz) begin
          seen[cap_dest] <= 1'b1;
          if (cfg.mode && seen[cap_dest]) begin
            conflicts <= conflicts + 1'b1;
          end
        end
      end
      // move one head packet
      if (mv) begin
        out_cnt[mv_d] <= out_cnt[mv_d] + 1'b1;
        in_head[mv_n] <= in_head[mv_n] + 1'b1;
        in_cnt[mv_n]  <= in_cnt[mv_n] - 1'b1;
        issued[mv_d]  <= 1'b1;
        grants        <= grants + 1'b1;
        if (cfg.mode && cdown == 8'd1) begin
          ptr[mv_d] <= mv_n + 1'b1;
        end
      end
      if (dcmd.arb && !cfg.mode && rr_conf) begin
        conflicts <= conflicts + 1'b1;
      end
      // end of tick
      if (dcmd.finish) begin
        if (!cfg.mode) begin
          rot <= rot + 1'b1;
        end else if (nz != '0) begin
          cdown <= (cdown == 8'd1) ? cfg.grant_period : cdown - 1'b1;
        end
      end
    end
  end

  // any queue occupied
  always_comb begin
    busy_res = 1'b0;
    for (int i = 0; i < NODES; i++) begin
      if (in_cnt[i] != '0 || out_cnt[i] != '0) busy_res = 1'b1;
    end
  end

  logic cnt_ovf;
  always_comb begin
    cnt_ovf = 1'b0;
    for (int i = 0; i < NODES; i++) begin
      if (in_cnt[i] > CNT_W'(QUEUE_DEPTH) || out_cnt[i] > CNT_W'(QUEUE_DEPTH)) cnt_ovf = 1'b1;
    end
  end

  // queue fill never passes the depth
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) !cnt_ovf)
    else $error("queue count beyond depth");

  // every head packet is either granted or blocked at most once per tick
  a_tick_total: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, grants} + {1'b0, conflicts}) <= 5'(NODES))
    else $error("grants plus conflicts exceed node count");

endmodule

// ===== rtl/crossbar_switch_arbiter.sv =====
// top level: register port, controller and datapath of the crossbar arbiter
// sequence: push goes through S_PUSH, pop through S_POP and, on a hit, S_POPW,
//   advance through S_SCAN and S_ARB, other commands straight to the done strobe
// throughput: one transaction at a time; advance is set by the head scan over the
//   input memory port and the arbitration sweep, each one node per cycle
// reset: all queues empty, start node, pointers zero, countdown one,
//   registers to mode 0, limits 8, grant period 1; results are never stalled
module crossbar_switch_arbiter import xsa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  output logic                  done,
  input  logic [1:0]            cmd,
  input  logic [NODE_W-1:0]     src_node,
  input  logic [NODE_W-1:0]     dst_node,
  input  logic [DATA_WIDTH-1:0] payload,
  input  logic [NODE_W-1:0]     pop_node,
  output logic                  push_accepted,
  output logic                  pop_valid,
  output logic [DATA_WIDTH-1:0] pop_data,
  output logic [3:0]            grants,
  output logic [3:0]            conflicts,
  output logic                  busy_res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t     cfg;
  dp_cmd_t  dcmd;
  dp_sts_t  sts;
  reg_idx_t ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[3:2]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= 1'b0;
      cfg.in_limit     <= 4'd8;
      cfg.out_limit    <= 4'd8;
      cfg.grant_period <= 8'd1;
    end else if (psel && penable && pwrite && pready) begin
      case (ridx)
        REG_MODE:      cfg.mode         <= pwdata[0];
        REG_IN_LIMIT:  cfg.in_limit     <= pwdata[3:0];
        REG_OUT_LIMIT: cfg.out_limit    <= pwdata[3:0];
        REG_GRANT:     cfg.grant_period <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (ridx)
      REG_MODE:      prdata = {31'd0, cfg.mode};
      REG_IN_LIMIT:  prdata = {28'd0, cfg.in_limit};
      REG_OUT_LIMIT: prdata = {28'd0, cfg.out_limit};
      REG_GRANT:     prdata = {24'd0, cfg.grant_period};
      default:       prdata = '0;
    endcase
  end

  xsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd_t'(cmd)),
    .sts   (sts),
    .dcmd  (dcmd),
    .busy  (busy),
    .done  (done)
  );

  xsa_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .dcmd          (dcmd),
    .sts           (sts),
    .src_node      (src_node),
    .dst_node      (dst_node),
    .payload       (payload),
    .pop_node      (pop_node),
    .push_accepted (push_accepted),
    .pop_valid     (pop_valid),
    .pop_data      (pop_data),
    .grants        (grants),
    .conflicts     (conflicts),
    .busy_res      (busy_res)
  );

endmodule
